>>> rtl/core/dtt_pkg.sv
// shared types and constants for the delimited text tokenizer
// no dependencies; the other files in rtl/core, apart from dtt_if.sv, refer to this package by scoped names
package dtt_pkg;

    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] DELIM_RESET   = 8'd44;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_REC_END  = 2'd2;
    localparam logic [1:0] KIND_QUOTE_ERR = 2'd3;

    // token queue depth; an item is taken only while at least half of it is free
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] QACCEPT_MAX = QCNT_W'(QDEPTH / 2);

    typedef struct packed {
        logic quoting_active;
        logic close_quote_pending;
        logic at_cell_begin;
        logic carriage_return_seen;
        logic cell_has_bytes;
        logic record_has_cells;
    } state_t;

    localparam state_t STATE_RESET = '{
        quoting_active:       1'b0,
        close_quote_pending:  1'b0,
        at_cell_begin:        1'b1,
        carriage_return_seen: 1'b0,
        cell_has_bytes:       1'b0,
        record_has_cells:     1'b0
    };

    typedef struct packed {
        logic [7:0] cell_byte;
        logic [1:0] token_kind;
        logic       run_last;
    } token_t;

    // result of one byte: new state and up to two tokens, in order
    typedef struct packed {
        state_t      st;
        logic [1:0]  tok_cnt;
        token_t      tok0;
        token_t      tok1;
    } step_t;

endpackage

>>> rtl/core/dtt_if.sv
// valid/ready channel interfaces for the tokenizer input bytes and output tokens
// depends on nothing; payload widths follow the field definitions
interface dtt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface dtt_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_byte;
    logic [1:0] token_kind;
    logic       run_last;

    modport source (output valid, output cell_byte, output token_kind, output run_last,
                    input ready);
    modport sink   (input valid, input cell_byte, input token_kind, input run_last,
                    output ready);
endinterface

>>> rtl/core/dtt_decode.sv
// per-byte decision logic: quoting, delimiter and record-end rules, end-of-text flush
// depends on dtt_pkg
module dtt_decode
(
    input  dtt_pkg::state_t st,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    input  logic [7:0]      delimiter_char,
    output dtt_pkg::step_t  step
);

    always_comb
    begin
        dtt_pkg::state_t s;
        logic            consumed;
        logic            main_vld;
        dtt_pkg::token_t main_tok;
        logic            fin_vld;
        dtt_pkg::token_t fin_tok;

        s        = st;
        consumed = 1'b0;
        main_vld = 1'b0;
        main_tok = '0;
        fin_vld  = 1'b0;
        fin_tok  = '0;

        // lf right after a record-ending cr is swallowed
        if (s.carriage_return_seen)
        begin
            s.carriage_return_seen = 1'b0;
            if (text_byte == dtt_pkg::CH_LF)
                consumed = 1'b1;
        end

        if (!consumed && s.close_quote_pending)
        begin
            s.close_quote_pending = 1'b0;
            if (text_byte == dtt_pkg::CH_QUOTE)
            begin
                main_vld            = 1'b1;
                main_tok.cell_byte  = dtt_pkg::CH_QUOTE;
                main_tok.token_kind = dtt_pkg::KIND_DATA;
                s.cell_has_bytes    = 1'b1;
                consumed            = 1'b1;
            end
            else
                s.quoting_active = 1'b0;
        end

        if (!consumed)
        begin
            if (s.quoting_active)
            begin
                if (text_byte == dtt_pkg::CH_QUOTE)
                    s.close_quote_pending = 1'b1;
                else
                begin
                    main_vld            = 1'b1;
                    main_tok.cell_byte  = text_byte;
                    main_tok.token_kind = dtt_pkg::KIND_DATA;
                    s.cell_has_bytes    = 1'b1;
                end
            end
            else if (s.at_cell_begin && text_byte == dtt_pkg::CH_QUOTE)
            begin
                s.quoting_active = 1'b1;
                s.at_cell_begin  = 1'b0;
            end
            else if (text_byte == delimiter_char)
            begin
                main_vld            = 1'b1;
                main_tok.token_kind = dtt_pkg::KIND_CELL_END;
                s.at_cell_begin     = 1'b1;
                s.cell_has_bytes    = 1'b0;
                s.record_has_cells  = 1'b1;
            end
            else if (text_byte == dtt_pkg::CH_CR || text_byte == dtt_pkg::CH_LF)
            begin
                main_vld               = 1'b1;
                main_tok.token_kind    = dtt_pkg::KIND_REC_END;
                s.at_cell_begin        = 1'b1;
                s.cell_has_bytes       = 1'b0;
                s.record_has_cells     = 1'b0;
                s.carriage_return_seen = (text_byte == dtt_pkg::CH_CR);
            end
            else
            begin
                main_vld            = 1'b1;
                main_tok.cell_byte  = text_byte;
                main_tok.token_kind = dtt_pkg::KIND_DATA;
                s.cell_has_bytes    = 1'b1;
                s.at_cell_begin     = 1'b0;
            end
        end

        // end of text: a pending close quote closes, then error or flush
        if (final_byte)
        begin
            if (s.close_quote_pending)
            begin
                s.close_quote_pending = 1'b0;
                s.quoting_active      = 1'b0;
            end
            if (s.quoting_active)
            begin
                fin_vld            = 1'b1;
                fin_tok.token_kind = dtt_pkg::KIND_QUOTE_ERR;
            end
            else if (s.cell_has_bytes || s.record_has_cells)
            begin
                fin_vld            = 1'b1;
                fin_tok.token_kind = dtt_pkg::KIND_REC_END;
            end
            s = dtt_pkg::STATE_RESET;
        end

        fin_tok.run_last  = 1'b1;
        main_tok.run_last = !fin_vld;

        step.st      = s;
        step.tok_cnt = {1'b0, main_vld} + {1'b0, fin_vld};
        step.tok0    = main_vld ? main_tok : fin_tok;
        step.tok1    = fin_tok;
    end

endmodule

>>> rtl/core/dtt_tok_fifo.sv
// token queue: takes zero, one or two tokens a cycle, hands out one a cycle while tokens.ready is high
// depends on dtt_pkg and dtt_token_if
module dtt_tok_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_cnt,
    input  dtt_pkg::token_t               push_tok0,
    input  dtt_pkg::token_t               push_tok1,
    output logic [dtt_pkg::QCNT_W-1:0]    count,
    dtt_token_if.source                   tokens
);

    dtt_pkg::token_t                 mem [dtt_pkg::QDEPTH];
    logic [dtt_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [dtt_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [dtt_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            pop;
    logic [dtt_pkg::QPTR_W-1:0]      wr_ptr_p1;

    assign pop       = tokens.valid && tokens.ready;
    assign wr_ptr_p1 = wr_ptr_reg + dtt_pkg::QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dtt_pkg::QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + dtt_pkg::QPTR_W'(pop);
        count_next  = count_reg + dtt_pkg::QCNT_W'(push_cnt) - dtt_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_tok0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_p1] <= push_tok1;
    end

    assign count             = count_reg;
    assign tokens.valid      = (count_reg != '0);
    assign tokens.cell_byte  = mem[rd_ptr_reg].cell_byte;
    assign tokens.token_kind = mem[rd_ptr_reg].token_kind;
    assign tokens.run_last   = mem[rd_ptr_reg].run_last;

endmodule

>>> rtl/core/delimited_text_tokenizer.sv
// top level of the delimited text tokenizer: input register, state, token queue
// depends on dtt_pkg, dtt_if.sv, dtt_decode and dtt_tok_fifo
//
//   channel   dir   payload                                    handshake
//   text      in    text_byte[7:0], final_byte                 valid/ready
//   tokens    out   cell_byte[7:0], token_kind[1:0], run_last  valid/ready
//   cfg       in    cfg_wdata[7:0] (delimiter)                 cfg_we, no ready
//
// one byte is taken per cycle while text.ready is high; it is decoded in
// the cycle after it is taken and its zero to two tokens enter the queue
// at the edge ending that cycle, the first one visible on tokens from that
// edge if the queue was empty. tokens leave one per cycle while
// tokens.ready is high. text.ready drops while the queue holds more than
// half its depth. reset empties the queue and sets the delimiter to comma.
module delimited_text_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    dtt_text_if.sink    text,
    dtt_token_if.source tokens
);

    logic                           in_vld_reg;
    logic [7:0]                     in_byte_reg;
    logic                           in_fin_reg;
    dtt_pkg::state_t                st_reg, st_next;
    logic [7:0]                     delim_reg;
    dtt_pkg::step_t                 step;
    logic [dtt_pkg::QCNT_W-1:0]     q_count;
    logic                           accept;
    logic [1:0]                     push_cnt;

    assign text.ready = (q_count <= dtt_pkg::QACCEPT_MAX);
    assign accept     = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= dtt_pkg::STATE_RESET;
            delim_reg  <= dtt_pkg::DELIM_RESET;
        end
        else
        begin
            in_vld_reg <= accept;
            st_reg     <= st_next;
            if (cfg_we)
                delim_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= text.text_byte;
            in_fin_reg  <= text.final_byte;
        end
    end

    dtt_decode u_decode
    (
        .st             (st_reg),
        .text_byte      (in_byte_reg),
        .final_byte     (in_fin_reg),
        .delimiter_char (delim_reg),
        .step           (step)
    );

    assign st_next  = in_vld_reg ? step.st : st_reg;
    assign push_cnt = in_vld_reg ? step.tok_cnt : 2'd0;

    dtt_tok_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_tok0 (step.tok0),
        .push_tok1 (step.tok1),
        .count     (q_count),
        .tokens    (tokens)
    );

    // queue must never overflow given the acceptance threshold
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= dtt_pkg::QCNT_W'(dtt_pkg::QDEPTH))
        else $error("token queue overflow");

    // a final byte leaves the parser state at its reset value
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_fin_reg) |=> (st_reg == dtt_pkg::STATE_RESET))
        else $error("state not cleared after final byte");

    // marker tokens carry a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.token_kind != dtt_pkg::KIND_DATA)
        |-> (tokens.cell_byte == 8'd0))
        else $error("marker token with nonzero byte");

    // a byte decoded into two tokens always ends with the last-of-run flag
    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && step.tok_cnt == 2'd2) |-> (step.tok1.run_last && !step.tok0.run_last))
        else $error("run_last misplaced");

endmodule
